@@ design/tse_pkg.sv @@
// Package for the Taylor series elementary function engine.
// Holds formats, function codes, the reciprocal table and the cell-to-cell record.
// No dependencies.
package tse_pkg;

    localparam int NumTermsDefault = 18;
    localparam int ArgW = 32;
    localparam int ResW = 48;
    localparam int MagW = 63;
    localparam int AccW = 52;

    typedef enum logic [1:0] {
        FUNC_SIN = 2'd0,
        FUNC_COS = 2'd1,
        FUNC_EXP = 2'd2,
        FUNC_LN  = 2'd3
    } func_t;

    localparam logic [MagW-1:0] TermCap = MagW'(64'd1 << 62);
    localparam logic signed [AccW-1:0] AccLim = AccW'(64'sd1 <<< 50);
    localparam logic signed [AccW-1:0] ResMax = AccW'((64'sd1 <<< 47) - 1);
    localparam logic signed [AccW-1:0] ResMin = AccW'(-(64'sd1 <<< 47));

    typedef struct packed {
        logic                   valid;
        func_t                  func;
        logic                   skip;
        logic [ArgW-1:0]        xmag;
        logic                   xneg;
        logic [MagW-1:0]        mag;
        logic                   tneg;
        logic signed [AccW-1:0] acc;
        logic                   ovf;
        logic                   last;
    } cell_rec_t;

    function automatic logic [31:0] recip_rom(input logic [5:0] k);
        logic [6:0] kk;
        logic [32:0] num;
        begin
            kk = (k == 6'd0) ? 7'd1 : {1'b0, k};
            num = 33'h080000000 + 33'(kk >> 1);
            return 32'(num / 33'(kk));
        end
    endfunction

    // split into a low 32-bit and a high 31-bit part of a, one partial product each
    function automatic logic [MagW-1:0] umulsh(input logic [MagW-1:0] a, input logic [31:0] b,
                                               input logic sh31, output logic ovf);
        logic [63:0] plo;
        logic [63:0] phi;
        logic [63:0] r;
        begin
            plo = 64'(a[31:0]) * 64'(b) + (sh31 ? (64'd1 << 30) : (64'd1 << 27));
            phi = 64'(a[MagW-1:32]) * 64'(b);
            ovf = 1'b0;
            if (sh31) begin
                if (phi >= 64'(TermCap >> 1))
                    ovf = 1'b1;
                r = (phi << 1) + (plo >> 31);
            end else begin
                if (phi >= 64'(TermCap >> 4))
                    ovf = 1'b1;
                r = (phi << 4) + (plo >> 28);
            end
            if (!ovf && r > 64'(TermCap))
                ovf = 1'b1;
            return ovf ? TermCap : MagW'(r);
        end
    endfunction

    function automatic logic signed [AccW-1:0] add_term(input logic signed [AccW-1:0] acc,
                                                       input logic [MagW-1:0] mag,
                                                       input logic neg, output logic ovf);
        logic signed [64:0] s;
        begin
            s = neg ? 65'(acc) - $signed({2'b0, mag}) : 65'(acc) + $signed({2'b0, mag});
            ovf = 1'b0;
            if (s > 65'(AccLim)) begin
                s = 65'(AccLim);
                ovf = 1'b1;
            end else if (s < -65'(AccLim)) begin
                s = -65'(AccLim);
                ovf = 1'b1;
            end
            return AccW'(s);
        end
    endfunction

endpackage

@@ design/tse_mul_cell.sv @@
// Multiply stage of one series cell: term times the argument magnitude.
// Depends on tse_pkg.
module tse_mul_cell import tse_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic [5:0] k,
    input  cell_rec_t rec_in,
    output cell_rec_t rec_out
);
    cell_rec_t rec_reg, rec_next;
    logic o;

    always_comb begin
        rec_next = rec_in;
        o = 1'b0;
        if (rec_in.valid && !rec_in.skip && k != 6'd0) begin
            if (!(rec_in.func == FUNC_LN && k == 6'd1)) begin
                rec_next.mag = umulsh(rec_in.mag, rec_in.xmag, 1'b0, o);
                rec_next.tneg = rec_in.tneg ^ rec_in.xneg;
                rec_next.ovf = rec_in.ovf | o;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.valid <= 1'b0;
        end else if (adv) begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;
endmodule

@@ design/tse_div_cell.sv @@
// Reciprocal and accumulate stage of one series cell.
// Depends on tse_pkg.
module tse_div_cell import tse_pkg::*; #(
    parameter logic [5:0] K = 6'd0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  cell_rec_t rec_in,
    output cell_rec_t rec_out
);
    localparam logic [31:0] Recip = recip_rom(K);

    cell_rec_t rec_reg, rec_next;
    logic [MagW-1:0] t;
    logic o1, o2, add, neg;
    logic signed [AccW-1:0] sum;

    always_comb begin
        rec_next = rec_in;
        o1 = 1'b0;
        o2 = 1'b0;
        t = rec_in.mag;
        add = 1'b0;
        neg = rec_in.tneg;
        if (K != 6'd0)
            t = umulsh(rec_in.mag, Recip, 1'b1, o1);
        unique case (rec_in.func)
            FUNC_EXP: add = 1'b1;
            FUNC_SIN: begin
                add = K[0];
                neg = rec_in.tneg ^ K[1];
            end
            FUNC_COS: begin
                add = !K[0];
                neg = rec_in.tneg ^ K[1];
            end
            default: begin
                add = (K != 6'd0);
                neg = rec_in.tneg ^ !K[0];
            end
        endcase
        sum = add_term(rec_in.acc, t, neg, o2);
        if (rec_in.valid && !rec_in.skip) begin
            if (rec_in.func != FUNC_LN)
                rec_next.mag = t;
            if (rec_in.func == FUNC_LN && K == 6'd0) begin
                rec_next.ovf = rec_in.ovf;
            end else begin
                rec_next.ovf = rec_in.ovf | o1 | (add & o2);
                if (add)
                    rec_next.acc = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.valid <= 1'b0;
        end else if (adv) begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;
endmodule

@@ design/taylor_series_elementary_functions.sv @@
// Top level of the Taylor series engine for sine, cosine, exp and ln.
// Depends on tse_pkg, tse_mul_cell and tse_div_cell.
// One argument is taken every cycle unless the output stalls; results pass a row of
// two-stage term cells (twice NUM_TERMS cells; sine and cosine use them all).
module taylor_series_elementary_functions import tse_pkg::*; #(
    parameter int NUM_TERMS = NumTermsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], arg_value[33:2], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // result_value[47:0], overflow_flag[48], zeros
);
    localparam int NCells = 2 * NUM_TERMS;

    cell_rec_t link [NCells*2+1];
    cell_rec_t in_rec, in_reg;
    logic adv;
    logic [ArgW-1:0] raw;
    logic signed [ArgW:0] xs, y;
    logic m_valid_reg;
    logic [ResW:0] m_data_reg;
    logic signed [AccW-1:0] fin;
    logic fovf;

    assign adv = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign raw = s_tdata[33:2];
    assign xs = $signed({raw[ArgW-1], raw});
    assign y = xs - (ArgW+1)'(33'sd1 <<< 28);

    always_comb begin
        in_rec.valid = s_tvalid;
        in_rec.func = func_t'(s_tdata[1:0]);
        in_rec.skip = 1'b0;
        in_rec.xneg = raw[ArgW-1];
        in_rec.xmag = raw[ArgW-1] ? (32'd0 - raw) : raw;
        in_rec.mag = MagW'(64'd1 << 32);
        in_rec.tneg = 1'b0;
        in_rec.acc = '0;
        in_rec.ovf = 1'b0;
        in_rec.last = 1'b0;
        if (in_rec.func == FUNC_LN) begin
            in_rec.xneg = y[ArgW];
            in_rec.xmag = y[ArgW] ? 32'(-y) : 32'(y);
            in_rec.mag = MagW'({in_rec.xmag, 4'd0});
            in_rec.tneg = y[ArgW];
            if (xs <= 0) begin
                in_rec.skip = 1'b1;
                in_rec.acc = ResMin;
                in_rec.ovf = 1'b1;
            end else if (xs > (ArgW+1)'(33'sd1 <<< 29)) begin
                in_rec.skip = 1'b1;
                in_rec.acc = ResMax;
                in_rec.ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (adv) begin
            in_reg <= in_rec;
        end
    end

    assign link[0] = in_reg;

    for (genvar i = 0; i < NCells; i++) begin : g_cell
        cell_rec_t mid, cin;
        always_comb begin
            cin = link[2*i];
            if ((cin.func == FUNC_EXP && i >= NUM_TERMS) ||
                (cin.func == FUNC_LN && i >= NUM_TERMS))
                cin.skip = 1'b1;
        end
        tse_mul_cell u_mul (.aclk(aclk), .aresetn(aresetn), .adv(adv), .k(6'(i)),
                            .rec_in(cin), .rec_out(mid));
        tse_div_cell #(.K(6'(i))) u_div (.aclk(aclk), .aresetn(aresetn), .adv(adv),
                                         .rec_in(mid), .rec_out(link[2*i+2]));
        assign link[2*i+1] = mid;
    end

    always_comb begin
        fin = link[NCells*2].acc;
        fovf = link[NCells*2].ovf;
        if (fin > ResMax) begin
            fin = ResMax;
            fovf = 1'b1;
        end else if (fin < ResMin) begin
            fin = ResMin;
            fovf = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= link[NCells*2].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {fovf, fin[ResW-1:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_data_reg};
endmodule

@@ design/tse_checker.sv @@
// Port-level checker for the Taylor series engine, bound to the top level.
// Depends on taylor_series_elementary_functions.
module tse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a held result");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:49] == 7'd0)
        else $error("padding bits set");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind taylor_series_elementary_functions tse_checker u_tse_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Taylor series engine (sine, cosine, exp, ln).
// Drives random and directed arguments with random gaps and stalls, predicts each sum.
// Depends on tse_pkg and taylor_series_elementary_functions.
module testbench;
    import tse_pkg::*;

    localparam int NumTerms = 18;
    localparam int Latency = 4 * NumTerms + 2;
    localparam int RandomItems = 1830;
    localparam logic [47:0] ResMaxBits = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ResMinBits = 48'h8000_0000_0000;

    typedef struct packed {
        logic [47:0] value;
        logic        ovf;
    } series_res_t;

    typedef struct {
        func_t       fn;
        logic [31:0] x;
        bit          fixed;
        series_res_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    series_res_t sums_due[$];
    stim_row_t   rows[$];
    int          mismatches;
    int          results_seen;
    int          func_count[4];
    bit          sending_done;

    taylor_series_elementary_functions #(.NUM_TERMS(NumTerms)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic void add_row(input stim_row_t r);
        rows = {rows, r};
    endfunction

    function automatic void queue_sum(input series_res_t s);
        sums_due = {sums_due, s};
    endfunction

    function automatic logic [62:0] scale_mag(input logic [62:0] a, input logic [31:0] b,
                                              input int sh, inout bit ovf);
        logic [95:0] prod;
        begin
            prod = (96'(a) * 96'(b) + (96'd1 << (sh - 1))) >> sh;
            if (prod > 96'(64'd1 << 62)) begin
                ovf = 1'b1;
                return 63'(64'd1 << 62);
            end
            return prod[62:0];
        end
    endfunction

    function automatic logic [31:0] inv_k(input int k);
        longint unsigned kk;
        begin
            kk = longint'(k & 63);
            if (kk == 0) kk = 1;
            return 32'(((64'd1 << 31) + (kk >> 1)) / kk);
        end
    endfunction

    function automatic void accumulate(inout longint acc, input logic [62:0] mag,
                                       input bit neg, inout bit ovf);
        longint s;
        longint lim;
        begin
            lim = 64'sd1 <<< 50;
            s = neg ? acc - longint'(mag) : acc + longint'(mag);
            if (s > lim) begin
                s = lim;
                ovf = 1'b1;
            end else if (s < -lim) begin
                s = -lim;
                ovf = 1'b1;
            end
            acc = s;
        end
    endfunction

    function automatic series_res_t series_sum(input func_t fn, input logic [31:0] raw);
        bit          xneg, ovf, tneg, yneg;
        logic [31:0] xmag, ymag;
        logic [62:0] t;
        logic [62:0] tk;
        longint      acc, xs, y;
        int          limit;
        series_res_t r;
        begin
            xneg = raw[31];
            xmag = xneg ? -raw : raw;
            acc = 0;
            ovf = 1'b0;
            if (fn == FUNC_LN) begin
                xs = longint'($signed(raw));
                if (xs <= 0) begin
                    acc = -(64'sd1 <<< 47);
                    ovf = 1'b1;
                end else if (xs > (64'sd1 <<< 29)) begin
                    acc = (64'sd1 <<< 47) - 1;
                    ovf = 1'b1;
                end else begin
                    y = xs - (64'sd1 <<< 28);
                    yneg = y < 0;
                    ymag = 32'(yneg ? -y : y);
                    t = 63'(ymag) << 4;
                    tneg = yneg;
                    for (int k = 1; k < NumTerms; k++) begin
                        if (k > 1) begin
                            t = scale_mag(t, ymag, 28, ovf);
                            tneg = tneg != yneg;
                        end
                        tk = scale_mag(t, inv_k(k), 31, ovf);
                        accumulate(acc, tk, tneg != ((k & 1) == 0), ovf);
                    end
                end
            end else begin
                t = 63'(64'd1 << 32);
                tneg = 1'b0;
                limit = (fn == FUNC_EXP) ? NumTerms : 2 * NumTerms;
                for (int k = 0; k < limit; k++) begin
                    if (k > 0) begin
                        t = scale_mag(t, xmag, 28, ovf);
                        t = scale_mag(t, inv_k(k), 31, ovf);
                        tneg = tneg != xneg;
                    end
                    if (fn == FUNC_EXP)
                        accumulate(acc, t, tneg, ovf);
                    else if ((k & 1) == ((fn == FUNC_SIN) ? 1 : 0))
                        accumulate(acc, t, tneg != (((k >> 1) & 1) != 0), ovf);
                end
            end
            if (acc > (64'sd1 <<< 47) - 1) begin
                acc = (64'sd1 <<< 47) - 1;
                ovf = 1'b1;
            end else if (acc < -(64'sd1 <<< 47)) begin
                acc = -(64'sd1 <<< 47);
                ovf = 1'b1;
            end
            r.value = acc[47:0];
            r.ovf = ovf;
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        begin
            mismatches++;
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    task automatic send_arg(input func_t fn, input logic [31:0] x);
        int gap;
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {6'd0, x, fn};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            func_count[fn]++;
        end
    endtask

    function automatic logic [31:0] random_arg(input func_t fn);
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (fn == FUNC_LN && pick < 7)
                return 32'($urandom_range(1, 32'h2000_0000));
            if (pick < 6)
                return 32'($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
            return $urandom;
        end
    endfunction

    // stimulus: directed table first, then random arguments
    initial begin
        stim_row_t row;
        func_t     fn;
        logic [31:0] xs[8];
        s_tvalid = 1'b0;
        s_tdata = '0;
        sending_done = 1'b0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        xs = '{32'h0, 32'h1000_0000, 32'hF000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h2000_0000, 32'h2000_0001, 32'h0000_0001};
        foreach (xs[i]) for (int f = 0; f < 3; f++) begin
            row = '{func_t'(f), xs[i], 1'b0, '0};
            add_row(row);
        end
        add_row('{FUNC_LN, 32'h0, 1'b1, '{ResMinBits, 1'b1}});
        add_row('{FUNC_LN, 32'h8000_0000, 1'b1, '{ResMinBits, 1'b1}});
        add_row('{FUNC_LN, 32'hFFFF_FFFF, 1'b1, '{ResMinBits, 1'b1}});
        add_row('{FUNC_LN, 32'h2000_0001, 1'b1, '{ResMaxBits, 1'b1}});
        add_row('{FUNC_LN, 32'h7FFF_FFFF, 1'b1, '{ResMaxBits, 1'b1}});
        add_row('{FUNC_LN, 32'h1000_0000, 1'b1, '{48'h0, 1'b0}});
        add_row('{FUNC_LN, 32'h2000_0000, 1'b0, '0});
        add_row('{FUNC_LN, 32'h0000_0001, 1'b0, '0});

        foreach (rows[i]) begin
            queue_sum(rows[i].fixed ? rows[i].res : series_sum(rows[i].fn, rows[i].x));
            send_arg(rows[i].fn, rows[i].x);
        end
        for (int n = 0; n < RandomItems; n++) begin
            fn = func_t'($urandom_range(0, 3));
            row.x = random_arg(fn);
            queue_sum(series_sum(fn, row.x));
            send_arg(fn, row.x);
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // result side: random stalls, compare against the oldest expectation
    initial begin
        series_res_t want;
        int stall;
        m_tready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
            if (sums_due.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[47:0], '0);
            end else begin
                want = sums_due.pop_front();
                if (m_tdata[47:0] !== want.value)
                    report_mismatch("result_value", m_tdata[47:0], want.value);
                if (m_tdata[48] !== want.ovf)
                    report_mismatch("overflow_flag", 48'(m_tdata[48]), 48'(want.ovf));
            end
        end
    end

    initial begin
        wait (sending_done);
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (Latency + 20) @(posedge aclk);
        $display("Covered %0d sums: sin %0d, cos %0d, exp %0d, ln %0d", results_seen,
                 func_count[0], func_count[1], func_count[2], func_count[3]);
        if (mismatches == 0 && sums_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

@@ files.f @@
design/tse_pkg.sv
design/tse_mul_cell.sv
design/tse_div_cell.sv
design/taylor_series_elementary_functions.sv
design/tse_checker.sv
tb/sv/testbench.sv
